// ===== hdl/p2g_pkg.sv =====
// ----------------------------------------------------------------------------
// p2g_pkg: shared types and constants of the 2D polynomial evaluator
// Operand and product widths of the shared multiplier and stream widths.
// ----------------------------------------------------------------------------
package p2g_pkg;

    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 192;

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

endpackage

// ===== hdl/p2g_ram.sv =====
// ----------------------------------------------------------------------------
// p2g_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module p2g_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/p2g_mul.sv =====
// ----------------------------------------------------------------------------
// p2g_mul: shared unsigned multiplier
// 32 x 32 bit product with a registered result, one issue per cycle.
// ----------------------------------------------------------------------------
module p2g_mul
    import p2g_pkg::*;
(
    input  logic              aclk,
    input  mul_req_t          req,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(req.a) * PROD_W'(req.b);
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/poly2d_eval_with_gradient.sv =====
// ----------------------------------------------------------------------------
// poly2d_eval_with_gradient: 2D polynomial value and gradient, fixed point
// Input stream (s_): tuser selects write or evaluate and the wave table.
//   A write stores one Q16.32 coefficient and completes in the accept cycle;
//   writes may follow back to back and produce no result.
//   An evaluation scales (x, z) and walks the triangular term list, z power
//   outer and x power inner, with one shared 32 x 32 multiplier.
// Output stream (m_): value, d/dx * x_scale, d/dz * z_scale in tdata and the
//   saturation flag in tuser, one transaction per evaluation.
// Each term product issues the power product, then the low and the high
//   coefficient half, on the shared multiplier.
// s_tready is high only while idle. A finished result sits in the output
// register; a stalled receiver holds it there and the next result waits
// until it is taken, while the block may already accept and run a new item.
// Reset (aresetn low, synchronous) empties the output and restores
// poly_order 8 and both scales to 1.0; the coefficient tables are not cleared.
// ----------------------------------------------------------------------------
module poly2d_eval_with_gradient
    import p2g_pkg::*;
#(
    parameter int MAX_TERMS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_addr,
    input  logic [17:0]          cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // coef_index, coef_value, x_pos, z_pos, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode, wave_select
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // value, slope_x, slope_z
    output logic [M_TDATA_W-1:0] m_tdata,
    // overflow
    output logic [0:0]           m_tuser
);

    localparam int AW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int IJ_W = 7;
    localparam logic [IJ_W:0] TERMS_LIM = (IJ_W + 1)'(MAX_TERMS);

    localparam logic [1:0] CFG_ORDER  = 2'd0;
    localparam logic [1:0] CFG_XSCALE = 2'd1;
    localparam logic [1:0] CFG_ZSCALE = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [31:0] ONE_Q28  = 32'h1000_0000;
    localparam logic [31:0] PWR_MAX  = 32'hFFFF_FFFF;
    localparam logic [63:0] POS_LIM  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIM  = 64'h8000_0000_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SX, ST_SZ, ST_ZC, ST_T_F, ST_T_P, ST_T_PC, ST_T_H,
        ST_UX, ST_UXC, ST_UZ, ST_UZC, ST_FN_MAG, ST_FN_HI, ST_FN_LO,
        ST_FN_ADD, ST_FN_SGN, ST_DONE
    } state_t;

    typedef enum logic [1:0] {KIND_VAL, KIND_DX, KIND_DZ} kind_t;

    state_t state_reg, state_next;

    // configuration
    logic [3:0]  order_reg;
    logic [17:0] x_scale_reg, z_scale_reg;

    // input fields
    logic        s_opcode, s_wave;
    logic [5:0]  s_coef_index;
    logic [47:0] s_coef_value;
    logic [23:0] s_x_pos, s_z_pos;
    logic        accept, eval_start, wr_ok;

    // datapath
    logic [23:0] x_pos_reg, z_pos_reg;
    logic        wave_reg;
    logic [31:0] x_reg, z_reg, xx_reg, xx0_reg, zz_reg, zz0_reg;
    logic        xx_sat_reg, xx0_sat_reg, zz_sat_reg, zz0_sat_reg;
    logic [3:0]  i_reg, j_reg;
    logic [IJ_W-1:0] ij_reg;
    kind_t       kind_reg;
    logic [47:0] mag_reg;
    logic        neg_reg;
    logic [31:0] p_reg;
    logic [63:0] lo_reg;
    logic [63:0] sum_reg, sdx_reg, sdz_reg;
    logic        ov_reg;
    logic        fin_z_reg, fneg_reg, fbig_reg;
    logic [63:0] fmag_reg, fr_reg;
    logic [49:0] h_reg;

    // accumulate tail: A (reduce), M (weight), C (saturating add)
    logic        ta_valid_reg, tm_valid_reg, tc_valid_reg;
    kind_t       ta_kind_reg, tm_kind_reg, tc_kind_reg;
    logic [3:0]  ta_w_reg, tm_w_reg;
    logic        ta_neg_reg, tm_neg_reg, tc_neg_reg;
    logic [50:0] r_reg;
    logic [54:0] wm_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 out_load;

    // combinational helpers
    mul_req_t          mreq;
    logic [PROD_W-1:0] prod;
    logic [47:0]       rd_p, rd_s, rd;
    logic [31:0]       p_now;
    logic              p_ovf, sin_ovf, in_sat;
    logic              term_in_range, has_dx, has_dz, more_kind, j_last, i_last;
    logic [3:0]        kind_w;
    logic [17:0]       fin_scale;
    logic [79:0]       full;
    logic [63:0]       acc_sel, fin_src, fin_lim, fin_r;
    logic [64:0]       acc_sum;
    logic              fin_over;

    assign s_opcode     = s_tuser[0];
    assign s_wave       = s_tuser[1];
    assign s_coef_index = s_tdata[5:0];
    assign s_coef_value = s_tdata[53:6];
    assign s_x_pos      = s_tdata[77:54];
    assign s_z_pos      = s_tdata[101:78];

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign eval_start = accept && (s_opcode == OP_EVAL);
    assign wr_ok      = accept && (s_opcode == OP_WRITE) && ({2'b00, s_coef_index} < TERMS_LIM);

    // ------------------------------------------------------------------------
    // coefficient tables and shared multiplier
    // ------------------------------------------------------------------------
    p2g_ram #(.WIDTH(48), .DEPTH(MAX_TERMS), .AW(AW)) u_tab_p (
        .aclk  (aclk),
        .we    (wr_ok && !s_wave),
        .waddr (s_coef_index[AW-1:0]),
        .wdata (s_coef_value),
        .raddr (ij_reg[AW-1:0]),
        .rdata (rd_p)
    );

    p2g_ram #(.WIDTH(48), .DEPTH(MAX_TERMS), .AW(AW)) u_tab_s (
        .aclk  (aclk),
        .we    (wr_ok && s_wave),
        .waddr (s_coef_index[AW-1:0]),
        .wdata (s_coef_value),
        .raddr (ij_reg[AW-1:0]),
        .rdata (rd_s)
    );

    p2g_mul u_mul (
        .aclk (aclk),
        .req  (mreq),
        .prod (prod)
    );

    assign rd = wave_reg ? rd_s : rd_p;

    assign p_ovf   = |prod[63:60];
    assign p_now   = p_ovf ? PWR_MAX : prod[59:28];
    assign sin_ovf = |prod[63:36];

    assign term_in_range = ({1'b0, ij_reg} < TERMS_LIM);
    assign has_dx        = (j_reg != 4'd0);
    assign has_dz        = (i_reg != 4'd0);
    assign more_kind     = ((kind_reg == KIND_VAL) && (has_dx || has_dz)) ||
                           ((kind_reg == KIND_DX) && has_dz);
    assign j_last        = (({1'b0, j_reg} + 5'd1) >= {1'b0, order_reg - i_reg});
    assign i_last        = (({1'b0, i_reg} + 5'd1) >= {1'b0, order_reg});
    assign fin_scale     = fin_z_reg ? z_scale_reg : x_scale_reg;

    always_comb begin
        unique case (kind_reg)
            KIND_DX: begin
                in_sat = xx0_sat_reg || zz_sat_reg;
                kind_w = j_reg;
            end
            KIND_DZ: begin
                in_sat = xx_sat_reg || zz0_sat_reg;
                kind_w = i_reg;
            end
            default: begin
                in_sat = xx_sat_reg || zz_sat_reg;
                kind_w = 4'd1;
            end
        endcase
    end

    always_comb begin
        mreq = '0;
        unique case (state_reg)
            ST_SX: begin
                mreq.a = MUL_W'(x_pos_reg);
                mreq.b = MUL_W'(x_scale_reg);
            end
            ST_SZ: begin
                mreq.a = MUL_W'(z_pos_reg);
                mreq.b = MUL_W'(z_scale_reg);
            end
            ST_T_P: begin
                unique case (kind_reg)
                    KIND_DX: begin
                        mreq.a = xx0_reg;
                        mreq.b = zz_reg;
                    end
                    KIND_DZ: begin
                        mreq.a = xx_reg;
                        mreq.b = zz0_reg;
                    end
                    default: begin
                        mreq.a = xx_reg;
                        mreq.b = zz_reg;
                    end
                endcase
            end
            ST_T_PC: begin
                mreq.a = mag_reg[31:0];
                mreq.b = p_now;
            end
            ST_T_H: begin
                mreq.a = MUL_W'(mag_reg[47:32]);
                mreq.b = p_reg;
            end
            ST_UX: begin
                mreq.a = xx_reg;
                mreq.b = x_reg;
            end
            ST_UZ: begin
                mreq.a = zz_reg;
                mreq.b = z_reg;
            end
            ST_FN_HI: begin
                mreq.a = fmag_reg[63:32];
                mreq.b = MUL_W'(fin_scale);
            end
            ST_FN_LO: begin
                mreq.a = fmag_reg[31:0];
                mreq.b = MUL_W'(fin_scale);
            end
            default: begin
                mreq = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (eval_start) state_next = ST_SX;
            ST_SX:     state_next = ST_SZ;
            ST_SZ:     state_next = ST_ZC;
            ST_ZC:     state_next = (order_reg == 4'd0) ? ST_FN_MAG : ST_T_F;
            ST_T_F:    state_next = term_in_range ? ST_T_P : ST_UX;
            ST_T_P:    state_next = ST_T_PC;
            ST_T_PC:   state_next = ST_T_H;
            ST_T_H:    state_next = more_kind ? ST_T_P : ST_UX;
            ST_UX:     state_next = ST_UXC;
            ST_UXC:    state_next = j_last ? ST_UZ : ST_T_F;
            ST_UZ:     state_next = ST_UZC;
            ST_UZC:    state_next = i_last ? ST_FN_MAG : ST_T_F;
            ST_FN_MAG: state_next = ST_FN_HI;
            ST_FN_HI:  state_next = ST_FN_LO;
            ST_FN_LO:  state_next = ST_FN_ADD;
            ST_FN_ADD: state_next = ST_FN_SGN;
            ST_FN_SGN: state_next = fin_z_reg ? ST_DONE : ST_FN_MAG;
            ST_DONE:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (out_load) begin
            m_tdata_reg <= {sdz_reg, sdx_reg, sum_reg};
            m_tuser_reg <= ov_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // ------------------------------------------------------------------------
    // configuration and tail control
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg    <= 4'd8;
            x_scale_reg  <= 18'h10000;
            z_scale_reg  <= 18'h10000;
            ta_valid_reg <= 1'b0;
            tm_valid_reg <= 1'b0;
            tc_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_ORDER:  order_reg   <= cfg_wdata[3:0];
                    CFG_XSCALE: x_scale_reg <= cfg_wdata;
                    CFG_ZSCALE: z_scale_reg <= cfg_wdata;
                    default:    ;
                endcase
            end
            ta_valid_reg <= (state_reg == ST_T_H);
            tm_valid_reg <= ta_valid_reg;
            tc_valid_reg <= tm_valid_reg;
        end
    end

    // ------------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------------
    assign full = {16'd0, lo_reg} + {prod[47:0], 32'd0};

    always_comb begin
        unique case (tc_kind_reg)
            KIND_DX: acc_sel = sdx_reg;
            KIND_DZ: acc_sel = sdz_reg;
            default: acc_sel = sum_reg;
        endcase
        if (tc_neg_reg) begin
            acc_sum = {acc_sel[63], acc_sel} - {10'd0, wm_reg};
        end else begin
            acc_sum = {acc_sel[63], acc_sel} + {10'd0, wm_reg};
        end
    end

    assign fin_src  = fin_z_reg ? sdz_reg : sdx_reg;
    assign fin_lim  = fneg_reg ? NEG_LIM : POS_LIM;
    assign fin_over = fbig_reg || (fr_reg > fin_lim);
    assign fin_r    = fin_over ? fin_lim : fr_reg;

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (eval_start) begin
                    x_pos_reg <= s_x_pos;
                    z_pos_reg <= s_z_pos;
                    wave_reg  <= s_wave;
                    ov_reg    <= 1'b0;
                    sum_reg   <= '0;
                    sdx_reg   <= '0;
                    sdz_reg   <= '0;
                    fin_z_reg <= 1'b0;
                end
            end
            ST_SZ: begin
                if (sin_ovf) begin
                    x_reg  <= PWR_MAX;
                    ov_reg <= 1'b1;
                end else begin
                    x_reg <= prod[35:4];
                end
            end
            ST_ZC: begin
                if (sin_ovf) begin
                    z_reg  <= PWR_MAX;
                    ov_reg <= 1'b1;
                end else begin
                    z_reg <= prod[35:4];
                end
                i_reg       <= '0;
                j_reg       <= '0;
                ij_reg      <= '0;
                xx_reg      <= ONE_Q28;
                xx0_reg     <= ONE_Q28;
                zz_reg      <= ONE_Q28;
                zz0_reg     <= ONE_Q28;
                xx_sat_reg  <= 1'b0;
                xx0_sat_reg <= 1'b0;
                zz_sat_reg  <= 1'b0;
                zz0_sat_reg <= 1'b0;
            end
            ST_T_F: begin
                kind_reg <= KIND_VAL;
            end
            ST_T_P: begin
                neg_reg <= rd[47];
                mag_reg <= rd[47] ? (48'd0 - rd) : rd;
            end
            ST_T_PC: begin
                p_reg <= p_now;
                if (p_ovf || in_sat) begin
                    ov_reg <= 1'b1;
                end
            end
            ST_T_H: begin
                lo_reg      <= prod;
                ta_kind_reg <= kind_reg;
                ta_w_reg    <= kind_w;
                ta_neg_reg  <= neg_reg;
                kind_reg    <= ((kind_reg == KIND_VAL) && has_dx) ? KIND_DX : KIND_DZ;
            end
            ST_UXC: begin
                xx0_reg     <= xx_reg;
                xx0_sat_reg <= xx_sat_reg;
                xx_reg      <= p_now;
                xx_sat_reg  <= xx_sat_reg || p_ovf;
                j_reg       <= j_reg + 4'd1;
                ij_reg      <= ij_reg + IJ_W'(1);
            end
            ST_UZC: begin
                zz0_reg     <= zz_reg;
                zz0_sat_reg <= zz_sat_reg;
                zz_reg      <= p_now;
                zz_sat_reg  <= zz_sat_reg || p_ovf;
                i_reg       <= i_reg + 4'd1;
                j_reg       <= '0;
                xx_reg      <= ONE_Q28;
                xx0_reg     <= ONE_Q28;
                xx_sat_reg  <= 1'b0;
                xx0_sat_reg <= 1'b0;
            end
            ST_FN_MAG: begin
                fneg_reg <= fin_src[63];
                fmag_reg <= fin_src[63] ? (64'd0 - fin_src) : fin_src;
            end
            ST_FN_LO: begin
                h_reg <= prod[49:0];
            end
            ST_FN_ADD: begin
                fbig_reg <= |h_reg[49:47];
                fr_reg   <= {1'b0, h_reg[46:0], 16'd0} + {30'd0, prod[49:16]};
            end
            ST_FN_SGN: begin
                if (fin_over) begin
                    ov_reg <= 1'b1;
                end
                if (fin_z_reg) begin
                    sdz_reg <= fneg_reg ? (64'd0 - fin_r) : fin_r;
                end else begin
                    sdx_reg <= fneg_reg ? (64'd0 - fin_r) : fin_r;
                end
                fin_z_reg <= 1'b1;
            end
            default: ;
        endcase

        if (ta_valid_reg) begin
            r_reg       <= full[78:28];
            tm_kind_reg <= ta_kind_reg;
            tm_w_reg    <= ta_w_reg;
            tm_neg_reg  <= ta_neg_reg;
        end

        if (tm_valid_reg) begin
            wm_reg      <= r_reg * tm_w_reg;
            tc_kind_reg <= tm_kind_reg;
            tc_neg_reg  <= tm_neg_reg;
        end

        if (tc_valid_reg) begin
            if (acc_sum[64] != acc_sum[63]) begin
                ov_reg <= 1'b1;
                unique case (tc_kind_reg)
                    KIND_DX: sdx_reg <= acc_sum[64] ? NEG_LIM : POS_LIM;
                    KIND_DZ: sdz_reg <= acc_sum[64] ? NEG_LIM : POS_LIM;
                    default: sum_reg <= acc_sum[64] ? NEG_LIM : POS_LIM;
                endcase
            end else begin
                unique case (tc_kind_reg)
                    KIND_DX: sdx_reg <= acc_sum[63:0];
                    KIND_DZ: sdz_reg <= acc_sum[63:0];
                    default: sum_reg <= acc_sum[63:0];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_tail_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FN_MAG) |-> !(ta_valid_reg || tm_valid_reg || tc_valid_reg))
        else $error("final scaling started with a term still in flight");

    a_term_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_T_P) |-> term_in_range)
        else $error("product issued for a term beyond the table");

    a_degree: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_T_P) |-> (({1'b0, i_reg} + {1'b0, j_reg}) < {1'b0, order_reg}))
        else $error("term degree not below poly_order");

    a_dx_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_T_P && kind_reg == KIND_DX) |-> (j_reg != 4'd0))
        else $error("x derivative pass with zero weight");

endmodule

// ===== verif/poly2d_eval_with_gradient_tb.sv =====
// ----------------------------------------------------------------------------
// poly2d_eval_with_gradient_tb: self-checking bench for the 2D polynomial unit
// Loads both coefficient tables, runs directed corner evaluations (reset
// settings, coefficient and position extremes, zero order, term limit, scale
// extremes, unused register index), then random writes and evaluations under
// four handshake pressure phases. Each result is compared field by field with
// a bit-exact fixed-point predictor of the value, gradient and overflow flag.
// ----------------------------------------------------------------------------
module poly2d_eval_with_gradient_tb;
    import p2g_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          COEF_DEPTH     = 64;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          PRINT_LIMIT    = 60;
    localparam logic [31:0] ONE_Q28        = 32'h1000_0000;
    localparam logic [23:0] POS_ONE        = 24'h01_0000;
    localparam logic [17:0] SCALE_ONE      = 18'h1_0000;
    localparam logic [17:0] SCALE_MAX      = 18'h3_FFFF;

    typedef enum logic {OP_WRITE = 1'b0, OP_EVAL = 1'b1} op_e;
    typedef enum logic {WAVE_P = 1'b0, WAVE_S = 1'b1} wave_e;
    typedef enum logic [1:0] {
        REG_ORDER   = 2'd0,
        REG_X_SCALE = 2'd1,
        REG_Z_SCALE = 2'd2,
        REG_SPARE   = 2'd3
    } reg_e;

    typedef struct packed {
        logic [63:0] value;
        logic [63:0] slope_x;
        logic [63:0] slope_z;
        logic        overflow;
    } eval_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [1:0]           cfg_addr;
    logic [17:0]          cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    // coef_index, coef_value, x_pos, z_pos, zero pad
    logic [S_TDATA_W-1:0] s_tdata;
    // opcode, wave_select
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // value, slope_x, slope_z
    logic [M_TDATA_W-1:0] m_tdata;
    // overflow
    logic [0:0]           m_tuser;

    longint       coef_mem [2][COEF_DEPTH];
    logic [3:0]   poly_order_q;
    logic [17:0]  x_scale_q;
    logic [17:0]  z_scale_q;
    eval_result_t expected_results[$];

    int send_idle_pct;
    int stall_pct;
    int error_count;
    int quiet_cycles;
    int n_writes;
    int n_evals;
    int n_results;
    int n_saturated;

    poly2d_eval_with_gradient #(
        .MAX_TERMS (COEF_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------------
    function automatic logic [31:0] q28_mul(input logic [31:0] a, input logic [31:0] b,
                                            inout bit sat);
        logic [63:0] p;
        p = ({32'b0, a} * {32'b0, b}) >> 28;
        if (p[63:32] != 32'b0) begin
            sat = 1'b1;
            return 32'hFFFF_FFFF;
        end
        return p[31:0];
    endfunction

    function automatic logic [31:0] scale_coord(input logic [23:0] pos, input logic [17:0] k,
                                                inout bit ov);
        logic [63:0] p;
        p = ({40'b0, pos} * {46'b0, k}) >> 4;
        if (p[63:32] != 32'b0) begin
            ov = 1'b1;
            return 32'hFFFF_FFFF;
        end
        return p[31:0];
    endfunction

    function automatic longint coef_term(input longint c, input logic [31:0] p);
        logic [63:0] mag;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] r;
        mag = (c < 0) ? -c : c;
        hi  = mag * {48'b0, p[31:16]};
        lo  = mag * {48'b0, p[15:0]};
        r   = (hi + (lo >> 16)) >> 12;
        return (c < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint sat_add(input longint a, input longint b, inout bit ov);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            ov = 1'b1;
            return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return s[63:0];
    endfunction

    function automatic longint scale_slope(input longint s, input logic [17:0] k, inout bit ov);
        logic [63:0] mag;
        logic [63:0] h;
        logic [63:0] lim;
        logic [63:0] r;
        mag = (s < 0) ? -s : s;
        h   = {32'b0, mag[63:32]} * {46'b0, k};
        lim = (s < 0) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (h >= 64'h0000_8000_0000_0000) begin
            r  = lim;
            ov = 1'b1;
        end else begin
            r = (h << 16) + (({32'b0, mag[31:0]} * {46'b0, k}) >> 16);
            if (r > lim) begin
                r  = lim;
                ov = 1'b1;
            end
        end
        return (s < 0) ? longint'(-r) : longint'(r);
    endfunction

    function automatic eval_result_t predict_eval(input wave_e wave, input logic [23:0] xp,
                                                  input logic [23:0] zp);
        eval_result_t r;
        bit           ov;
        bit           s;
        bit           nz;
        bit           xx_sat;
        bit           xx0_sat;
        bit           zz_sat;
        bit           zz0_sat;
        logic [31:0]  x;
        logic [31:0]  z;
        logic [31:0]  xx;
        logic [31:0]  xx0;
        logic [31:0]  zz;
        logic [31:0]  zz0;
        logic [31:0]  p;
        longint       sum;
        longint       sdx;
        longint       sdz;
        longint       f;
        int           n;
        int           i;
        int           j;
        int           ij;
        ov = 1'b0;
        sum = 0;
        sdx = 0;
        sdz = 0;
        ij = 0;
        n = int'(poly_order_q);
        zz = ONE_Q28;
        zz0 = ONE_Q28;
        zz_sat = 1'b0;
        zz0_sat = 1'b0;
        x = scale_coord(xp, x_scale_q, ov);
        z = scale_coord(zp, z_scale_q, ov);
        for (i = 0; i < n; i++) begin
            xx = ONE_Q28;
            xx0 = ONE_Q28;
            xx_sat = 1'b0;
            xx0_sat = 1'b0;
            for (j = 0; j < n - i; j++) begin
                if (ij < COEF_DEPTH) begin
                    f = coef_mem[wave][ij];
                    s = xx_sat || zz_sat;
                    p = q28_mul(xx, zz, s);
                    if (s) ov = 1'b1;
                    sum = sat_add(sum, coef_term(f, p), ov);
                    if (j != 0) begin
                        s = xx0_sat || zz_sat;
                        p = q28_mul(xx0, zz, s);
                        if (s) ov = 1'b1;
                        sdx = sat_add(sdx, coef_term(f, p) * j, ov);
                    end
                    if (i != 0) begin
                        s = xx_sat || zz0_sat;
                        p = q28_mul(xx, zz0, s);
                        if (s) ov = 1'b1;
                        sdz = sat_add(sdz, coef_term(f, p) * i, ov);
                    end
                end
                ij++;
                xx0 = xx;
                xx0_sat = xx_sat;
                nz = 1'b0;
                xx = q28_mul(xx, x, nz);
                xx_sat = xx_sat || nz;
            end
            zz0 = zz;
            zz0_sat = zz_sat;
            nz = 1'b0;
            zz = q28_mul(zz, z, nz);
            zz_sat = zz_sat || nz;
        end
        sdx = scale_slope(sdx, x_scale_q, ov);
        sdz = scale_slope(sdz, z_scale_q, ov);
        r.value = sum;
        r.slope_x = sdx;
        r.slope_z = sdz;
        r.overflow = ov;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_item(input op_e op, input wave_e wave, input logic [5:0] idx,
                             input logic [47:0] coef, input logic [23:0] xp,
                             input logic [23:0] zp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, zp, xp, coef, idx};
        s_tuser  <= {wave, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_WRITE) begin
            coef_mem[wave][idx] = longint'(signed'(coef));
            n_writes++;
        end else begin
            expected_results.push_back(predict_eval(wave, xp, zp));
            n_evals++;
        end
    endtask

    task automatic write_coef(input wave_e wave, input logic [5:0] idx, input logic [47:0] c);
        send_item(OP_WRITE, wave, idx, c, 24'($urandom), 24'($urandom));
    endtask

    task automatic eval_point(input wave_e wave, input logic [23:0] xp, input logic [23:0] zp);
        send_item(OP_EVAL, wave, 6'($urandom), 48'($urandom), xp, zp);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_e addr, input logic [17:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            REG_ORDER:   poly_order_q = data[3:0];
            REG_X_SCALE: x_scale_q = data;
            REG_Z_SCALE: z_scale_q = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [3:0] order, input logic [17:0] xs,
                              input logic [17:0] zs);
        settle();
        write_reg(REG_ORDER, {14'b0, order});
        write_reg(REG_X_SCALE, xs);
        write_reg(REG_Z_SCALE, zs);
    endtask

    function automatic logic [47:0] rand_coef();
        logic [47:0] c;
        c = {16'($urandom), 32'($urandom)};
        if ($urandom_range(1) == 1) c = {{12{c[35]}}, c[35:0]};
        return c;
    endfunction

    function automatic logic [23:0] rand_pos();
        case ($urandom_range(3))
            0:       return 24'($urandom);
            1:       return 24'($urandom_range(24'h0F_FFFF));
            default: return 24'($urandom_range(24'h01_FFFF));
        endcase
    endfunction

    function automatic logic [17:0] rand_scale();
        case ($urandom_range(6))
            0:       return 18'd0;
            1:       return SCALE_MAX;
            2:       return SCALE_ONE;
            default: return 18'($urandom_range(18'h0_4000, 18'h1_FFFF));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < PRINT_LIMIT)
            $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin : check_results
        eval_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (m_tuser[0]) n_saturated++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending, value", m_tdata[63:0], 64'b0);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[63:0] !== want.value)
                    report_mismatch("value", m_tdata[63:0], want.value);
                if (m_tdata[127:64] !== want.slope_x)
                    report_mismatch("slope_x", m_tdata[127:64], want.slope_x);
                if (m_tdata[191:128] !== want.slope_z)
                    report_mismatch("slope_z", m_tdata[191:128], want.slope_z);
                if (m_tuser[0] !== want.overflow)
                    report_mismatch("overflow", {63'b0, m_tuser[0]}, {63'b0, want.overflow});
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, expected_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic load_coef_tables();
        for (int w = 0; w < 2; w++)
            for (int k = 0; k < COEF_DEPTH; k++)
                write_coef(wave_e'(w), 6'(k), rand_coef());
    endtask

    task automatic test_reset_settings();
        eval_point(WAVE_P, 24'h00_0000, 24'h00_0000);
        eval_point(WAVE_S, POS_ONE, 24'h00_8000);
        eval_point(WAVE_P, 24'hFF_FFFF, 24'hFF_FFFF);
    endtask

    task automatic test_coef_extremes();
        write_coef(WAVE_P, 6'd0, 48'h7FFF_FFFF_FFFF);
        write_coef(WAVE_P, 6'd1, 48'h8000_0000_0000);
        write_coef(WAVE_P, 6'd2, 48'h0000_0000_0000);
        write_coef(WAVE_S, 6'd2, 48'hFFFF_FFFF_FFFF);
        set_config(4'd2, SCALE_ONE, SCALE_ONE);
        eval_point(WAVE_P, POS_ONE, POS_ONE);
        eval_point(WAVE_S, POS_ONE, POS_ONE);
        // x = 15.0 fits, x^2 saturates but is only used from order 3
        eval_point(WAVE_P, 24'h0F_0000, 24'h00_0000);
        set_config(4'd3, SCALE_ONE, SCALE_ONE);
        eval_point(WAVE_P, 24'h0F_0000, 24'h00_0000);
    endtask

    task automatic test_order_limits();
        set_config(4'd0, SCALE_ONE, SCALE_ONE);
        eval_point(WAVE_S, POS_ONE, POS_ONE);
        set_config(4'd11, SCALE_ONE, SCALE_ONE);
        eval_point(WAVE_P, 24'h00_C000, 24'h01_4000);
        set_config(4'd15, SCALE_ONE, SCALE_ONE);
        eval_point(WAVE_S, 24'h00_8000, 24'h00_8000);
    endtask

    task automatic test_scale_extremes();
        set_config(4'd4, 18'd0, SCALE_MAX);
        eval_point(WAVE_P, 24'hFF_FFFF, 24'h00_C000);
        set_config(4'd4, SCALE_MAX, 18'd0);
        eval_point(WAVE_S, 24'h03_FFFF, 24'hFF_FFFF);
    endtask

    task automatic test_spare_register();
        settle();
        write_reg(REG_SPARE, SCALE_MAX);
        eval_point(WAVE_P, POS_ONE, 24'h00_4000);
    endtask

    task automatic run_pressure_phase(input int idle_pct, input int stall, input int n_items);
        logic [3:0] order;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(8))
                0:       order = 4'd1;
                1:       order = 4'd15;
                2:       order = 4'($urandom_range(15));
                default: order = 4'($urandom_range(2, 8));
            endcase
            set_config(order, rand_scale(), rand_scale());
            if ($urandom_range(3) == 0) write_reg(REG_SPARE, 18'($urandom));
            send_idle_pct = idle_pct;
            stall_pct = stall;
            for (int n = 0; n < n_items / 3; n++) begin
                if ($urandom_range(9) < 4)
                    write_coef(wave_e'($urandom_range(1)), 6'($urandom), rand_coef());
                else
                    eval_point(wave_e'($urandom_range(1)), rand_pos(), rand_pos());
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_ORDER;
        cfg_wdata = 18'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        poly_order_q = 4'd8;
        x_scale_q = SCALE_ONE;
        z_scale_q = SCALE_ONE;
        send_idle_pct = 0;
        stall_pct = 0;
        error_count = 0;
        n_writes = 0;
        n_evals = 0;
        n_results = 0;
        n_saturated = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_coef_tables();
        test_reset_settings();
        test_coef_extremes();
        test_order_limits();
        test_scale_extremes();
        test_spare_register();
        run_pressure_phase(0, 0, 225);
        run_pressure_phase(53, 0, 225);
        run_pressure_phase(0, 53, 225);
        run_pressure_phase(13, 13, 225);

        settle();
        repeat (1500) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch("results never returned, count", expected_results.size(), 64'b0);
        $display("covered %0d coefficient writes and %0d evaluations over orders 0..15,",
                 n_writes, n_evals);
        $display("scale extremes and four pressure phases; %0d results, %0d saturated",
                 n_results, n_saturated);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/p2g_pkg.sv
hdl/p2g_ram.sv
hdl/p2g_mul.sv
hdl/poly2d_eval_with_gradient.sv
verif/poly2d_eval_with_gradient_tb.sv
